// ----- hw/rtl/bmp_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared constants, register indexes and helpers of the block-mean mosaic.
// ----------------------------------------------------------------------------
package bmp_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_BLOCK_DEF = 64;
	localparam int MAX_HEIGHT    = 4096;

	localparam int PIX_W      = 8;
	localparam int SUM_W      = 20;
	localparam int BCOL_W     = 10;
	localparam int ROW_W      = 12;
	localparam int BS_W       = 7;
	localparam int IW_W       = 11;
	localparam int IH_W       = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic [BS_W-1:0] BS_RST = 7'd8;
	localparam logic [IW_W-1:0] IW_RST = 11'd640;
	localparam logic [IH_W-1:0] IH_RST = 13'd480;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [PIX_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W+1)'(b);
		return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] sat_mean(input logic [SUM_W-1:0] q);
		return (q > SUM_W'(255)) ? PIX_W'(255) : q[PIX_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/bmp_if.sv -----
// ----------------------------------------------------------------------------
// bmp_pix_if / bmp_blk_if
// Valid/ready channels for incoming pixels and finished block means.
// ----------------------------------------------------------------------------
interface bmp_pix_if;
	logic                     valid;
	logic                     ready;
	logic [bmp_pkg::PIX_W-1:0] red;
	logic [bmp_pkg::PIX_W-1:0] green;
	logic [bmp_pkg::PIX_W-1:0] blue;
	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

interface bmp_blk_if;
	logic                      valid;
	logic                      ready;
	logic [bmp_pkg::BCOL_W-1:0] block_col;
	logic [bmp_pkg::ROW_W-1:0]  block_row;
	logic [bmp_pkg::PIX_W-1:0]  mean_red;
	logic [bmp_pkg::PIX_W-1:0]  mean_green;
	logic [bmp_pkg::PIX_W-1:0]  mean_blue;
	logic                      frame_done;
	modport source(output valid, block_col, block_row, mean_red, mean_green, mean_blue,
		frame_done, input ready);
	modport sink(input valid, block_col, block_row, mean_red, mean_green, mean_blue,
		frame_done, output ready);
endinterface

// ----- hw/rtl/bmp_ram.sv -----
// ----------------------------------------------------------------------------
// bmp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bmp_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/bmp_div.sv -----
// ----------------------------------------------------------------------------
// bmp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmp_div #(
	parameter int DVD_W = 20,
	parameter int DVS_W = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);
	localparam int CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DVD_W-1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ----- hw/rtl/block_mean_pixelation.sv -----
// ----------------------------------------------------------------------------
// block_mean_pixelation
// Block-mean mosaic over a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on pix in raster order; each finished block leaves on blk
// with its block column and row, the truncated mean of each channel and a
// frame_done flag on the last block of the frame. Edge blocks are clipped
// and divided by their true pixel count.
// Per-block-column running sums live in one RAM (three 20-bit channels a
// word). For each pixel the sums of its block column are read, then the
// updated sums are written back. A pixel that closes a block also waits
// for the serial dividers (one quotient bit a cycle, 20 bits) and the
// result load. A write to block_size re-derives the block position from
// the pixel position with the same divider, with pix.ready low meanwhile.
// After reset the sum RAM is cleared, all MAX_WIDTH words (1024 by
// default), while pix.ready stays low; config writes are taken meanwhile.
// The result sits in an output register: pixels keep flowing while it
// waits, and only the next finished block waits for blk.ready.
// ----------------------------------------------------------------------------
module block_mean_pixelation #(
	parameter int MAX_WIDTH = bmp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_BLOCK = bmp_pkg::MAX_BLOCK_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bmp_pix_if.sink                         pix,
	bmp_blk_if.source                       blk,
	input  logic                            cfg_we,
	input  logic [bmp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bmp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bmp_pkg::*;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int B_W   = $clog2(MAX_BLOCK + 1);
	localparam int CNT_W = 2 * B_W;
	localparam int RAM_W = 3 * SUM_W;

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_UPD   = 3'd2;
	localparam logic [2:0] ST_EWAIT = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_RCOL  = 3'd5;
	localparam logic [2:0] ST_RROW  = 3'd6;

	logic [2:0]       st_q;
	logic             pend_q;
	logic [COL_W-1:0] clr_q;

	logic [BS_W-1:0] bs_q;
	logic [IW_W-1:0] iw_q;
	logic [IH_W-1:0] ih_q;

	logic [B_W-1:0]   b_eff;
	logic [COL_W:0]   w_eff;
	logic [IH_W-1:0]  h_eff;

	logic [COL_W-1:0] pc_q;
	logic [ROW_W-1:0] pr_q;
	logic [B_W-1:0]   cib_q;
	logic [B_W-1:0]   rib_q;
	logic [B_W-1:0]   pm_q;
	logic [B_W-1:0]   rm_q;
	logic [COL_W-1:0] bcol_q;
	logic [ROW_W-1:0] brow_q;

	logic col_end, row_end, blk_col_end, blk_row_end, pm_end, rm_end;
	logic accept;
	logic [CNT_W-1:0] cnt_w;

	logic [PIX_W-1:0] r_s1, g_s1, b_s1;
	logic             load_s1, emit_s1, fd_s1;
	logic [COL_W-1:0] addr_s1;
	logic [ROW_W-1:0] brow_s1;
	logic [CNT_W-1:0] cnt_s1;

	logic [SUM_W-1:0] sr_s2, sg_s2, sb_s2;

	logic [RAM_W-1:0] rdata, wdata;
	logic [SUM_W-1:0] nr, ng, nb;
	logic             ram_we;
	logic [COL_W-1:0] waddr;

	logic             div_start;
	logic [SUM_W-1:0] dvd_r;
	logic [CNT_W-1:0] dvs;
	logic             done_r, done_g, done_b;
	logic [SUM_W-1:0] q_r, q_g, q_b;
	logic [CNT_W-1:0] rem_r, rem_g, rem_b;

	logic              out_v_q;
	logic [BCOL_W-1:0] oc_q;
	logic [ROW_W-1:0]  or_q;
	logic [PIX_W-1:0]  omr_q, omg_q, omb_q;
	logic              ofd_q;

	always_comb begin
		if (bs_q == '0) begin
			b_eff = B_W'(1);
		end else if (int'(bs_q) > MAX_BLOCK) begin
			b_eff = B_W'(MAX_BLOCK);
		end else begin
			b_eff = B_W'(bs_q);
		end
		if (iw_q == '0) begin
			w_eff = (COL_W+1)'(1);
		end else if (int'(iw_q) > MAX_WIDTH) begin
			w_eff = (COL_W+1)'(MAX_WIDTH);
		end else begin
			w_eff = (COL_W+1)'(iw_q);
		end
		if (ih_q == '0) begin
			h_eff = IH_W'(1);
		end else if (int'(ih_q) > MAX_HEIGHT) begin
			h_eff = IH_W'(MAX_HEIGHT);
		end else begin
			h_eff = ih_q;
		end
	end

	assign col_end     = {1'b0, pc_q} >= (w_eff - 1'b1);
	assign row_end     = {1'b0, pr_q} >= (h_eff - 1'b1);
	assign blk_col_end = col_end || (cib_q >= b_eff - 1'b1);
	assign blk_row_end = row_end || (rib_q >= b_eff - 1'b1);
	assign pm_end      = pm_q >= b_eff - 1'b1;
	assign rm_end      = rm_q >= b_eff - 1'b1;
	assign cnt_w       = (CNT_W'(cib_q) + 1'b1) * (CNT_W'(rib_q) + 1'b1);

	assign pix.ready = (st_q == ST_IDLE) && !pend_q;
	assign accept    = pix.valid && pix.ready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= BS_RST;
			iw_q <= IW_RST;
			ih_q <= IH_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BLOCK_SIZE:   bs_q <= BS_W'(cfg_data);
				REG_IMAGE_WIDTH:  iw_q <= IW_W'(cfg_data);
				REG_IMAGE_HEIGHT: ih_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sum RAM
	assign nr = load_s1 ? SUM_W'(r_s1) : sat_add(rdata[3*SUM_W-1:2*SUM_W], r_s1);
	assign ng = load_s1 ? SUM_W'(g_s1) : sat_add(rdata[2*SUM_W-1:SUM_W], g_s1);
	assign nb = load_s1 ? SUM_W'(b_s1) : sat_add(rdata[SUM_W-1:0], b_s1);

	assign ram_we = (st_q == ST_UPD) || (st_q == ST_CLR);
	assign waddr  = (st_q == ST_CLR) ? clr_q : addr_s1;
	assign wdata  = (st_q == ST_CLR) ? '0 : {nr, ng, nb};

	bmp_ram #(.WIDTH(RAM_W), .DEPTH(MAX_WIDTH), .AW(COL_W)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(bcol_q),
		.rdata(rdata)
	);

	// divider inputs
	always_comb begin
		div_start = 1'b0;
		dvd_r     = sr_s2;
		dvs       = cnt_s1;
		case (st_q)
			ST_IDLE: begin
				if (pend_q) begin
					div_start = 1'b1;
					dvd_r     = SUM_W'(pc_q);
					dvs       = CNT_W'(b_eff);
				end
			end
			ST_RCOL: begin
				if (done_r) begin
					div_start = 1'b1;
					dvd_r     = SUM_W'(pr_q);
					dvs       = CNT_W'(b_eff);
				end
			end
			ST_EWAIT: begin
				div_start = !out_v_q || blk.ready;
			end
			default: ;
		endcase
	end

	bmp_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_r (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dvd_r), .divisor(dvs),
		.done(done_r), .quotient(q_r), .remainder(rem_r)
	);
	bmp_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_g (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sg_s2), .divisor(dvs),
		.done(done_g), .quotient(q_g), .remainder(rem_g)
	);
	bmp_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_b (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sb_s2), .divisor(dvs),
		.done(done_b), .quotient(q_b), .remainder(rem_b)
	);

	// control and positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLR;
			pend_q  <= 1'b0;
			clr_q   <= '0;
			pc_q    <= '0;
			pr_q    <= '0;
			cib_q   <= '0;
			rib_q   <= '0;
			pm_q    <= '0;
			rm_q    <= '0;
			bcol_q  <= '0;
			brow_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == REG_BLOCK_SIZE) begin
				pend_q <= 1'b1;
			end else if (st_q == ST_IDLE && pend_q) begin
				pend_q <= 1'b0;
			end
			if (st_q == ST_DIV && done_r) begin
				out_v_q <= 1'b1;
			end else if (blk.ready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == COL_W'(MAX_WIDTH-1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pend_q) begin
						st_q <= ST_RCOL;
					end else if (accept) begin
						st_q <= ST_UPD;
						if (col_end) begin
							pc_q   <= '0;
							cib_q  <= '0;
							pm_q   <= '0;
							bcol_q <= '0;
							if (row_end) begin
								pr_q   <= '0;
								rib_q  <= '0;
								rm_q   <= '0;
								brow_q <= '0;
							end else begin
								pr_q  <= pr_q + 1'b1;
								rib_q <= blk_row_end ? '0 : rib_q + 1'b1;
								if (rm_end) begin
									rm_q   <= '0;
									brow_q <= brow_q + 1'b1;
								end else begin
									rm_q <= rm_q + 1'b1;
								end
							end
						end else begin
							pc_q  <= pc_q + 1'b1;
							cib_q <= blk_col_end ? '0 : cib_q + 1'b1;
							if (pm_end) begin
								pm_q   <= '0;
								bcol_q <= bcol_q + 1'b1;
							end else begin
								pm_q <= pm_q + 1'b1;
							end
						end
					end
				end
				ST_UPD: begin
					st_q <= emit_s1 ? ST_EWAIT : ST_IDLE;
				end
				ST_EWAIT: begin
					if (div_start) begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (done_r) begin
						st_q <= ST_IDLE;
					end
				end
				ST_RCOL: begin
					if (done_r) begin
						bcol_q <= COL_W'(q_r);
						pm_q   <= B_W'(rem_r);
						st_q   <= ST_RROW;
					end
				end
				ST_RROW: begin
					if (done_r) begin
						brow_q <= ROW_W'(q_r);
						rm_q   <= B_W'(rem_r);
						st_q   <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// item and sum registers
	always_ff @(posedge clk) begin
		if (accept) begin
			r_s1    <= pix.red;
			g_s1    <= pix.green;
			b_s1    <= pix.blue;
			load_s1 <= (rib_q == '0) && (cib_q == '0);
			emit_s1 <= blk_col_end && blk_row_end;
			fd_s1   <= col_end && row_end;
			addr_s1 <= bcol_q;
			brow_s1 <= brow_q;
			cnt_s1  <= cnt_w;
		end
		if (st_q == ST_UPD) begin
			sr_s2 <= nr;
			sg_s2 <= ng;
			sb_s2 <= nb;
		end
		if (st_q == ST_DIV && done_r) begin
			oc_q  <= BCOL_W'(addr_s1);
			or_q  <= brow_s1;
			omr_q <= sat_mean(q_r);
			omg_q <= sat_mean(q_g);
			omb_q <= sat_mean(q_b);
			ofd_q <= fd_s1 && done_g && done_b && (rem_g == rem_g) && (rem_b == rem_b);
		end
	end

	assign blk.valid      = out_v_q;
	assign blk.block_col  = oc_q;
	assign blk.block_row  = or_q;
	assign blk.mean_red   = omr_q;
	assign blk.mean_green = omg_q;
	assign blk.mean_blue  = omb_q;
	assign blk.frame_done = ofd_q;
endmodule

// ----- hw/rtl/bmp_chk.sv -----
// ----------------------------------------------------------------------------
// bmp_chk
// Port-level checks of the block-mean mosaic, bound to the top level.
// ----------------------------------------------------------------------------
module bmp_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           pix_valid,
	input logic                           pix_ready,
	input logic                           blk_valid,
	input logic                           blk_ready,
	input logic [bmp_pkg::BCOL_W-1:0]     block_col,
	input logic [bmp_pkg::PIX_W-1:0]      mean_red,
	input logic                           cfg_we,
	input logic [bmp_pkg::CFG_IDX_W-1:0]  cfg_idx
);
	import bmp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid && !blk_ready |=> blk_valid && $stable(block_col) && $stable(mean_red))
		else $error("stalled block item changed");

	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> !pix_ready)
		else $error("pixel taken while sum update pending");

	a_bs_recalc: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_idx == REG_BLOCK_SIZE |=> !pix_ready)
		else $error("pixel accepted before block position recompute");
endmodule

bind block_mean_pixelation bmp_chk u_bmp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.blk_valid (blk.valid),
	.blk_ready (blk.ready),
	.block_col (blk.block_col),
	.mean_red  (blk.mean_red),
	.cfg_we    (cfg_we),
	.cfg_idx   (cfg_idx)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Block-mean mosaic: pixel frames under many block and image sizes.
// ----------------------------------------------------------------------------
// An in-bench copy of the mosaic arithmetic predicts every finished block.
// Each block mean coming out is checked field by field against the oldest
// prediction. Directed frames cover the pixel extremes, clipped edge blocks
// and out-of-range register values. Random frames follow. Pixels arrive in
// bursts with gaps, and the result side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;
	import bmp_pkg::*;

	localparam int LIMIT = 600000;
	localparam int SETTLE = 64;

	typedef struct packed {
		logic [BCOL_W-1:0] block_col;
		logic [ROW_W-1:0]  block_row;
		logic [PIX_W-1:0]  mean_red;
		logic [PIX_W-1:0]  mean_green;
		logic [PIX_W-1:0]  mean_blue;
		logic              frame_done;
	} block_mean_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	bmp_pix_if pix_ch ();
	bmp_blk_if blk_ch ();

	block_mean_pixelation u_top (
		.clk(clk), .arst_n(arst_n), .pix(pix_ch), .blk(blk_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mosaic model state
	logic [SUM_W-1:0] red_acc [MAX_WIDTH_DEF];
	logic [SUM_W-1:0] green_acc [MAX_WIDTH_DEF];
	logic [SUM_W-1:0] blue_acc [MAX_WIDTH_DEF];
	int unsigned pos_x, pos_y, band_row, blk_x;
	logic [BS_W-1:0] side_reg;
	logic [IW_W-1:0] width_reg;
	logic [IH_W-1:0] height_reg;

	block_mean_t pending_means[$];
	int mismatches;
	int cycles;
	int burst_left;

	function automatic int unsigned clip_reg(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [SUM_W-1:0] acc_add(logic [SUM_W-1:0] a, logic [PIX_W-1:0] v);
		int unsigned s;
		s = a + v;
		return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] mean_of(logic [SUM_W-1:0] s, int unsigned n);
		int unsigned m;
		m = s / n;
		return (m > 255) ? 8'd255 : m[PIX_W-1:0];
	endfunction

	function automatic void mosaic_step(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
			logic [PIX_W-1:0] b);
		int unsigned bs, w, h, bc, n;
		bit col_end, row_end, bce, bre;
		block_mean_t m;
		bs = clip_reg(side_reg, MAX_BLOCK_DEF);
		w = clip_reg(width_reg, MAX_WIDTH_DEF);
		h = clip_reg(height_reg, MAX_HEIGHT);
		bc = pos_x / bs;
		if (bc >= MAX_WIDTH_DEF) bc = MAX_WIDTH_DEF - 1;
		col_end = pos_x >= w - 1;
		row_end = pos_y >= h - 1;
		bce = col_end || blk_x >= bs - 1;
		bre = row_end || band_row >= bs - 1;
		if (band_row == 0 && blk_x == 0) begin
			red_acc[bc] = r;
			green_acc[bc] = g;
			blue_acc[bc] = b;
		end else begin
			red_acc[bc] = acc_add(red_acc[bc], r);
			green_acc[bc] = acc_add(green_acc[bc], g);
			blue_acc[bc] = acc_add(blue_acc[bc], b);
		end
		if (bce && bre) begin
			n = (blk_x + 1) * (band_row + 1);
			m.block_col = bc[BCOL_W-1:0];
			m.block_row = ROW_W'((pos_y / bs) % 4096);
			m.mean_red = mean_of(red_acc[bc], n);
			m.mean_green = mean_of(green_acc[bc], n);
			m.mean_blue = mean_of(blue_acc[bc], n);
			m.frame_done = col_end && row_end;
			pending_means.push_back(m);
		end
		if (col_end) begin
			pos_x = 0;
			blk_x = 0;
			if (row_end) begin
				pos_y = 0;
				band_row = 0;
			end else begin
				pos_y++;
				band_row = bre ? 0 : band_row + 1;
			end
		end else begin
			pos_x++;
			blk_x = bce ? 0 : blk_x + 1;
		end
	endfunction

	// result side: check, then pick the next ready level
	int stall_period, stall_duty, stall_phase, stall_left;
	always @(posedge clk) begin
		block_mean_t got, want;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
		if (arst_n && blk_ch.valid && blk_ch.ready) begin
			got.block_col = blk_ch.block_col;
			got.block_row = blk_ch.block_row;
			got.mean_red = blk_ch.mean_red;
			got.mean_green = blk_ch.mean_green;
			got.mean_blue = blk_ch.mean_blue;
			got.frame_done = blk_ch.frame_done;
			if (pending_means.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected block: col %0d row %0d", got.block_col,
						got.block_row);
			end else begin
				want = pending_means.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"block mismatch: exp %0d %0d %0d %0d %0d %0d,",
							" got %0d %0d %0d %0d %0d %0d"},
							want.block_col, want.block_row, want.mean_red,
							want.mean_green, want.mean_blue, want.frame_done,
							got.block_col, got.block_row, got.mean_red,
							got.mean_green, got.mean_blue, got.frame_done);
				end
			end
		end
		if (stall_left == 0) begin
			stall_period = $urandom_range(1, 9);
			stall_duty = ($urandom_range(0, 3) == 0) ? stall_period :
				$urandom_range(1, stall_period);
			stall_left = $urandom_range(20, 300);
		end else begin
			stall_left--;
		end
		stall_phase = (stall_phase + 1) % stall_period;
		blk_ch.ready <= stall_phase < stall_duty;
	end

	task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
		int gap;
		pix_ch.valid <= 1'b1;
		pix_ch.red <= r;
		pix_ch.green <= g;
		pix_ch.blue <= b;
		do @(posedge clk); while (!pix_ch.ready);
		mosaic_step(r, g, b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				pix_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		pix_ch.valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_regs(int unsigned bs, int unsigned w, int unsigned h);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= REG_BLOCK_SIZE;
		cfg_data <= CFG_DATA_W'(bs);
		@(posedge clk);
		side_reg = BS_W'(bs);
		cfg_idx <= REG_IMAGE_WIDTH;
		cfg_data <= CFG_DATA_W'(w);
		@(posedge clk);
		width_reg = IW_W'(w);
		cfg_idx <= REG_IMAGE_HEIGHT;
		cfg_data <= CFG_DATA_W'(h);
		@(posedge clk);
		height_reg = IH_W'(h);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random(int n);
		repeat (n) send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
	endtask

	task automatic test_extremes();
		program_regs(2, 3, 3);
		for (int i = 0; i < 9; i++)
			send_pixel((i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'hFF : 8'h00,
				(i < 4) ? 8'hFF : 8'h01);
		program_regs(1, 1, 1);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_out_of_range();
		program_regs(0, 0, 0);
		send_random(3);
		program_regs(127, 5, 2);
		send_random(10);
		program_regs(64, 2047, 1);
		send_random(1024);
		program_regs(64, 1, 8191);
		send_random(70);
	endtask

	task automatic test_random_frames();
		int unsigned bs, w, h, n;
		int done;
		done = 0;
		while (done < 200) begin
			case ($urandom_range(0, 5))
				0: bs = 64;
				1: bs = 1;
				default: bs = $urandom_range(1, 9);
			endcase
			w = (bs == 64) ? $urandom_range(60, 70) : $urandom_range(1, 40);
			h = (bs == 64) ? $urandom_range(1, 4) : $urandom_range(1, 20);
			if (w * h > 300) h = 300 / w;
			if (h == 0) h = 1;
			program_regs(bs, w, h);
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h) : w * h;
			send_random(n);
			done += n;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_BLOCK_SIZE;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.red = '0;
		pix_ch.green = '0;
		pix_ch.blue = '0;
		blk_ch.ready = 1'b0;
		mismatches = 0;
		cycles = 0;
		burst_left = 0;
		stall_period = 1;
		stall_duty = 1;
		stall_phase = 0;
		stall_left = 0;
		for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
			red_acc[i] = '0;
			green_acc[i] = '0;
			blue_acc[i] = '0;
		end
		pos_x = 0;
		pos_y = 0;
		band_row = 0;
		blk_x = 0;
		side_reg = BS_RST;
		width_reg = IW_RST;
		height_reg = IH_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_out_of_range();
		test_random_frames();
		drain();
		if (mismatches == 0 && pending_means.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/bmp_pkg.sv
hw/rtl/bmp_if.sv
hw/rtl/bmp_ram.sv
hw/rtl/bmp_div.sv
hw/rtl/block_mean_pixelation.sv
hw/rtl/bmp_chk.sv
tb/sv/testbench.sv
